@@ hdl/dwc_pkg.sv @@
// Package: shared types and constants for the depthwise convolution unit
`timescale 1ns / 1ps
package dwc_pkg;
    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT     = 4096;

    typedef enum logic [1:0] {
        ACT_TAP   = 2'd0,
        ACT_BIAS  = 2'd1,
        ACT_PIXEL = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_KH    = 3'd0,
        REG_KW    = 3'd1,
        REG_IH    = 3'd2,
        REG_IW    = 3'd3,
        REG_SHIFT = 3'd4,
        REG_RELU  = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [11:0] row;
        logic [7:0]  col;
        logic        last;
        logic        produce;
    } pix_info_t;
endpackage

@@ hdl/dwc_line_mem.sv @@
// Line store: one column of previous image rows per word, registered read
`timescale 1ns / 1ps
module dwc_line_mem #(
    parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
    parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int DW         = 16 * ((MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ hdl/dwc_mac.sv @@
// Multiply-accumulate engine: one tap per cycle over the window while step is high
`timescale 1ns / 1ps
module dwc_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic               step,
    input  logic signed [15:0] pixel,
    input  logic signed [15:0] tap,
    input  logic [4:0]         frac_shift,
    output logic [15:0]        acc
);
    logic signed [31:0] prod;
    logic signed [31:0] shifted;
    logic [15:0]        acc_reg;
    logic [15:0]        acc_next;

    assign prod    = pixel * tap;
    assign shifted = prod >>> frac_shift;

    always_comb begin
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (step) begin
            acc_next = acc_reg + shifted[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

@@ hdl/depthwise_conv2d_fixed_point_unit.sv @@
// Top level: depthwise 2-D convolution, fixed point, one channel at a time
//
//  channel  dir  fields (tdata lsb first)            tuser
//  s_axis   in   value[15:0]                          action[1:0], tap_index[6:2]
//  m_axis   out  result[15:0] out_row[27:16] col[35:28]  tlast = last
//  cfg      in   cfg_index[2:0], cfg_data[12:0]       -
//
// A pixel with a full window passes through the request, a line store read, the
// taps one at a time through the single multiplier, and the bias and ReLU step.
// A pixel without a full window returns to idle after the line store read.
// Reset restores default geometry, shift and ReLU, and clears counters and bias;
// taps and stored rows hold garbage.
// m_axis is a register; a held result stalls only the bias and ReLU step.
`timescale 1ns / 1ps
module depthwise_conv2d_fixed_point_unit #(
    parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value
    input  logic [6:0]  s_axis_tuser,   // action, tap_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result, out_row, out_col, zero fill
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import dwc_pkg::*;

    localparam int NT  = MAX_KERNEL * MAX_KERNEL;
    localparam int TW  = (NT > 1) ? $clog2(NT) : 1;
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int LR  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int DW  = 16 * LR;

    logic [2:0]  kh_cfg_reg, kw_cfg_reg;
    logic [12:0] ih_cfg_reg;
    logic [8:0]  iw_cfg_reg;
    logic [4:0]  shift_reg;
    logic        relu_reg;

    logic [15:0] taps_reg [NT];
    logic [15:0] win_reg  [MAX_KERNEL][MAX_KERNEL];
    logic [15:0] bias_reg;
    logic [11:0] row_reg;
    logic [CW-1:0] col_reg;

    state_t state_reg, state_next;
    pix_info_t info_reg;
    logic [15:0] pix_reg;
    logic [KW-1:0] r_reg, c_reg;
    logic [TW-1:0] t_reg;
    logic [15:0] res_reg;
    logic        mv_reg;
    logic [11:0] orow_reg;
    logic [7:0]  ocol_reg;
    logic        olast_reg;

    logic [KW-1:0] kh, kw;
    logic [12:0]   h;
    logic [CW-1:0] w;
    logic [2:0]    kh_c, kw_c;
    logic [12:0]   ih_c;
    logic [8:0]    iw_c;

    action_t act;
    logic [4:0] tidx;
    logic s_fire, m_fire, pix_fire;
    logic out_go;
    logic [11:0] row_now;
    logic [CW-1:0] col_now;
    logic [12:0] row_inc;

    logic [DW-1:0] lm_rd, lm_wr;
    logic mac_clear, mac_step;
    logic [15:0] mac_acc;
    logic [15:0] sum;

    always_comb begin
        kh_c = (kh_cfg_reg == 3'd0) ? 3'd1 : kh_cfg_reg;
        kw_c = (kw_cfg_reg == 3'd0) ? 3'd1 : kw_cfg_reg;
        kh   = (32'(kh_c) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kh_c);
        kw   = (32'(kw_c) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kw_c);
        ih_c = (ih_cfg_reg == 13'd0) ? 13'd1 : ih_cfg_reg;
        h    = (ih_c > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : ih_c;
        iw_c = (iw_cfg_reg == 9'd0) ? 9'd1 : iw_cfg_reg;
        w    = (32'(iw_c) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(iw_c);
    end

    assign act      = action_t'(s_axis_tuser[1:0]);
    assign tidx     = s_axis_tuser[6:2];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_fire   = m_axis_tvalid && m_axis_tready;
    assign pix_fire = s_fire && (act == ACT_PIXEL);
    assign out_go   = (state_reg == ST_OUT) && (!mv_reg || m_fire);
    assign cfg_ready = 1'b1;

    // wrap counters that went stale after a geometry change
    always_comb begin
        row_inc = 13'(row_reg);
        col_now = col_reg;
        if (col_reg >= w) begin
            col_now = '0;
            row_inc = 13'(row_reg) + 13'd1;
        end
        row_now = (row_inc >= h) ? 12'd0 : row_inc[11:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kh_cfg_reg <= 3'd3;
            kw_cfg_reg <= 3'd3;
            ih_cfg_reg <= 13'd32;
            iw_cfg_reg <= 9'd32;
            shift_reg  <= 5'd8;
            relu_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_KH:    kh_cfg_reg <= cfg_data[2:0];
                REG_KW:    kw_cfg_reg <= cfg_data[2:0];
                REG_IH:    ih_cfg_reg <= cfg_data;
                REG_IW:    iw_cfg_reg <= cfg_data[8:0];
                REG_SHIFT: shift_reg  <= cfg_data[4:0];
                REG_RELU:  relu_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && act == ACT_TAP && 32'(tidx) < NT) begin
            taps_reg[TW'(tidx)] <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            if (s_fire && act == ACT_BIAS) begin
                bias_reg <= s_axis_tdata;
            end
            if (pix_fire) begin
                if (col_now + CW'(1) >= w) begin
                    col_reg <= '0;
                    row_reg <= (13'(row_now) + 13'd1 >= h) ? 12'd0 : row_now + 12'd1;
                end else begin
                    col_reg <= col_now + CW'(1);
                    row_reg <= row_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_fire) begin
            pix_reg       <= s_axis_tdata;
            info_reg.row  <= row_now - 12'(kh) + 12'd1;
            info_reg.col  <= 8'(col_now) - 8'(kw) + 8'd1;
            info_reg.last <= (13'(row_now) == h - 13'd1) && (col_now == w - CW'(1));
            info_reg.produce <= (13'(row_now) + 13'd1 >= 13'(kh))
                             && (col_now + CW'(1) >= CW'(kw));
        end
    end

    logic [AW-1:0] lm_addr_reg;
    always_ff @(posedge aclk) begin
        if (pix_fire) begin
            lm_addr_reg <= AW'(col_now);
        end
    end

    // column shift: older rows move up, new pixel enters the bottom
    always_comb begin
        for (int i = 0; i < LR; i++) begin
            if (i + 1 < LR) begin
                lm_wr[16*i +: 16] = lm_rd[16*(i+1) +: 16];
            end else begin
                lm_wr[16*i +: 16] = pix_reg;
            end
        end
    end

    dwc_line_mem #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_line (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (lm_addr_reg),
        .wr_data (lm_wr),
        .rd_en   (pix_fire),
        .rd_addr (AW'(col_now)),
        .rd_data (lm_rd)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            for (int r = 0; r < MAX_KERNEL; r++) begin
                for (int c = 0; c + 1 < MAX_KERNEL; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r + 1 < MAX_KERNEL; r++) begin
                win_reg[r][MAX_KERNEL-1] <= lm_rd[16*r +: 16];
            end
            win_reg[MAX_KERNEL-1][MAX_KERNEL-1] <= pix_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pix_fire) state_next = ST_READ;
            ST_READ: state_next = info_reg.produce ? ST_MAC : ST_IDLE;
            ST_MAC:  if (r_reg == kh - KW'(1) && c_reg == kw - KW'(1)) state_next = ST_OUT;
            ST_OUT:  if (!mv_reg || m_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mac_clear = (state_reg == ST_READ);
        mac_step  = (state_reg == ST_MAC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg <= '0;
            c_reg <= '0;
            t_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_READ) begin
                r_reg <= '0;
                c_reg <= '0;
                t_reg <= '0;
            end else if (state_reg == ST_MAC) begin
                t_reg <= t_reg + TW'(1);
                if (c_reg == kw - KW'(1)) begin
                    c_reg <= '0;
                    r_reg <= r_reg + KW'(1);
                end else begin
                    c_reg <= c_reg + KW'(1);
                end
            end
        end
    end

    logic [KW-1:0] wr_idx, wc_idx;
    assign wr_idx = KW'(MAX_KERNEL) - kh + r_reg;
    assign wc_idx = KW'(MAX_KERNEL) - kw + c_reg;

    dwc_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (mac_clear),
        .step       (mac_step),
        .pixel      (win_reg[wr_idx][wc_idx]),
        .tap        (taps_reg[t_reg]),
        .frac_shift (shift_reg),
        .acc        (mac_acc)
    );

    assign sum = mac_acc + bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (out_go) begin
            mv_reg <= 1'b1;
        end else if (m_fire) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_go) begin
            res_reg   <= (relu_reg && sum[15]) ? 16'd0 : sum;
            orow_reg  <= info_reg.row;
            ocol_reg  <= info_reg.col;
            olast_reg <= info_reg.last;
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {4'd0, ocol_reg, orow_reg, res_reg};
    assign m_axis_tlast  = olast_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("request taken while busy");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> m_axis_tvalid)
        else $error("result lost");
endmodule

@@ sim/tb_top.sv @@
// Testbench for the depthwise convolution unit: random streams checked against a predictor
`timescale 1ns / 1ps
module tb_top;
    import dwc_pkg::*;

    typedef struct {
        logic [15:0] res;
        logic [11:0] row;
        logic [7:0]  col;
        logic        last;
    } conv_out_t;

    class conv_scoreboard;
        conv_out_t   pending_q[$];
        int          errors;
        int          kh_r, kw_r, ih_r, iw_r, shift_r, relu_r;
        logic [15:0] lines[5][256];
        logic [15:0] win[5][5];
        logic [15:0] taps[25];
        logic [15:0] bias;
        int          row_cnt, col_cnt;

        function new();
            kh_r = 3; kw_r = 3; ih_r = 32; iw_r = 32; shift_r = 8; relu_r = 0;
            bias = '0; row_cnt = 0; col_cnt = 0; errors = 0;
            foreach (lines[r, c]) lines[r][c] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            foreach (taps[i]) taps[i] = '0;
        endfunction

        function void set_reg(reg_index_t idx, logic [12:0] d);
            case (idx)
                REG_KH:    kh_r = d[2:0];
                REG_KW:    kw_r = d[2:0];
                REG_IH:    ih_r = d;
                REG_IW:    iw_r = d[8:0];
                REG_SHIFT: shift_r = d[4:0];
                REG_RELU:  relu_r = d[0];
                default: ;
            endcase
        endfunction

        function int clampi(int v, int lo, int hi);
            return (v < lo) ? lo : (v > hi) ? hi : v;
        endfunction

        function void note(action_t a, logic [4:0] ti, logic [15:0] v);
            int kh, kw, h, w, row, col, p;
            logic [31:0] q;
            logic [15:0] acc;
            conv_out_t e;
            case (a)
                ACT_TAP:  if (ti < 25) taps[ti] = v;
                ACT_BIAS: bias = v;
                ACT_PIXEL: begin
                    kh = clampi(kh_r, 1, 5);
                    kw = clampi(kw_r, 1, 5);
                    h = clampi(ih_r, 1, 4096);
                    w = clampi(iw_r, 1, 256);
                    if (col_cnt >= w) begin
                        col_cnt = 0;
                        row_cnt++;
                    end
                    if (row_cnt >= h) row_cnt = 0;
                    col = col_cnt;
                    row = row_cnt;
                    for (int r = 0; r < 5; r++)
                        for (int c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
                    for (int r = 0; r < 4; r++) win[r][4] = lines[r][col];
                    win[4][4] = v;
                    for (int r = 0; r < 4; r++) lines[r][col] = (r < 3) ? lines[r + 1][col] : v;
                    if (row + 1 >= kh && col + 1 >= kw) begin
                        acc = '0;
                        for (int r = 0; r < kh; r++)
                            for (int c = 0; c < kw; c++) begin
                                p = int'($signed(win[5 - kh + r][5 - kw + c]))
                                    * int'($signed(taps[r * kw + c]));
                                q = p >>> shift_r;
                                acc = acc + q[15:0];
                            end
                        acc = acc + bias;
                        if (relu_r != 0 && acc[15]) acc = '0;
                        e.res = acc;
                        e.row = 12'(row + 1 - kh);
                        e.col = 8'(col + 1 - kw);
                        e.last = (row == h - 1 && col == w - 1);
                        pending_q.push_back(e);
                    end
                    col_cnt = col + 1;
                    if (col_cnt >= w) begin
                        col_cnt = 0;
                        row_cnt = row + 1;
                        if (row_cnt >= h) row_cnt = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check(logic [15:0] res, logic [11:0] row, logic [7:0] col, logic last);
            conv_out_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h row %0d col %0d", res, row, col);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (res !== e.res) begin
                $error("result: expected %h actual %h", e.res, res);
                errors++;
            end
            if (row !== e.row) begin
                $error("out_row: expected %0d actual %0d", e.row, row);
                errors++;
            end
            if (col !== e.col) begin
                $error("out_col: expected %0d actual %0d", e.col, col);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [6:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    conv_scoreboard sb;
    int             n_items;
    int             rx_wait;
    bit             calm;

    depthwise_conv2d_fixed_point_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check(m_axis_tdata[15:0], m_axis_tdata[27:16], m_axis_tdata[35:28], m_axis_tlast);
            rx_wait <= calm ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(action_t a, logic [4:0] ti, logic [15:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge aclk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= {ti, a};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note(a, ti, v);
        n_items++;
    endtask

    task automatic drain();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [12:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic configure(int kh, int kw, int ih, int iw, int sh, int relu);
        write_reg(REG_KH, 13'(kh));
        write_reg(REG_KW, 13'(kw));
        write_reg(REG_IH, 13'(ih));
        write_reg(REG_IW, 13'(iw));
        write_reg(REG_SHIFT, 13'(sh));
        write_reg(REG_RELU, 13'(relu));
    endtask

    task automatic load_kernel(bit extras);
        for (int i = 0; i < 25; i++) send(ACT_TAP, 5'(i), pick_value());
        if (extras) begin
            send(ACT_TAP, 5'($urandom_range(25, 31)), pick_value());
            send(ACT_NONE, 5'($urandom), pick_value());
        end
        send(ACT_BIAS, 5'($urandom), pick_value());
    endtask

    task automatic push_pixels(int n);
        for (int i = 0; i < n; i++) send(ACT_PIXEL, 5'($urandom), pick_value());
    endtask

    initial begin
        int kh, kw, ih, iw;
        sb = new();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_wait = 0;
        calm = 1'b0;
        n_items = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        configure(5, 5, 5, 5, 0, 0);
        load_kernel(1'b1);
        push_pixels(25);
        drain();
        configure(3, 3, 3, 3, 31, 1);
        load_kernel(1'b1);
        push_pixels(9);
        drain();
        configure(5, 5, 3, 3, 8, 0);
        push_pixels(9);
        drain();
        configure(0, 7, 0, 0, 4, 0);
        push_pixels(3);
        drain();
        configure(1, 1, 1, 511, 2, 1);
        calm = 1'b1;
        push_pixels(256);
        calm = 1'b0;
        drain();
        configure(1, 1, 8191, 1, 1, 0);
        push_pixels(40);
        drain();
        configure(2, 2, 6, 8, 6, 0);
        load_kernel(1'b0);
        push_pixels(21);
        drain();
        write_reg(REG_IW, 13'd3);
        write_reg(REG_SHIFT, 13'd12);
        push_pixels(12);
        drain();

        while (n_items < 700) begin
            kh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            kw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            ih = $urandom_range(1, 8);
            iw = $urandom_range(1, 12);
            calm = ($urandom_range(0, 3) == 0);
            configure(kh, kw, ih, iw, $urandom_range(0, 31), $urandom_range(0, 1));
            load_kernel($urandom_range(0, 2) == 0);
            push_pixels(ih * iw);
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
